@@ design/cfts_pkg.sv @@
// Shared types, codes and constants of the CAN frame table scheduler.
// Used by cfts_ctrl, cfts_dp and can_frame_table_scheduler. No dependencies.
package cfts_pkg;

    // default table depth and per-tick frame limit
    localparam int SlotsDef = 6;
    localparam int MaxOut = 6;

    // validity multiple after reset, saturation length
    localparam logic [3:0] MultReset = 4'd2;
    localparam logic [3:0] MaxLen = 4'd8;

    // request operation codes
    typedef enum logic [2:0] {
        OP_REG  = 3'd0,
        OP_REM  = 3'd1,
        OP_RXF  = 3'd2,
        OP_TICK = 3'd3,
        OP_WRTX = 3'd4,
        OP_RDRX = 3'd5
    } t_op;

    // result kinds
    typedef enum logic [1:0] {
        KIND_ACK = 2'd0,
        KIND_TX  = 2'd1,
        KIND_RD  = 2'd2,
        KIND_ERR = 2'd3
    } t_kind;

    // one table entry
    typedef struct packed {
        logic [10:0] ident;
        logic [3:0]  len;
        logic [15:0] period;
        logic [31:0] ts;
        logic [63:0] data;
        logic        fresh;
    } t_entry;

    // one result
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  slot;
        logic [10:0] id;
        logic [3:0]  len;
        logic [63:0] payload;
        logic        fresh;
        logic        matched;
        logic        last;
    } t_result;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
        logic match;
        logic no_match;
        logic tx_scan;
        logic idx_clr;
        logic rx_scan;
        logic tick_done;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic [2:0] op;
        logic       tx_end;
        logic       rx_end;
        logic       hit;
    } t_sts;

    // keep the low len bytes, len of 8 or more keeps all
    function automatic logic [63:0] byte_mask(input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int k = 0; k < 8; k++) begin
            if (len > 4'(k)) begin
                m[8*k +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

@@ design/cfts_ctrl.sv @@
// Sequencer of the CAN frame table scheduler: accepts requests and steps
// the datapath through its scans. Depends on cfts_pkg.
module cfts_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  cfts_pkg::t_sts i_sts,
    output cfts_pkg::t_cmd o_cmd
);
    import cfts_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_MATCH  = 5'b00100,
        S_TXSCAN = 5'b01000,
        S_RXSCAN = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.op == OP_RXF) begin
                    n_state = S_MATCH;
                end else if (i_sts.op == OP_TICK) begin
                    n_state = S_TXSCAN;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_MATCH: begin
                if (i_sts.rx_end) begin
                    o_cmd.no_match = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.match = 1'b1;
                    if (i_sts.hit) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_TXSCAN: begin
                if (i_sts.tx_end) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state = S_RXSCAN;
                end else begin
                    o_cmd.tx_scan = 1'b1;
                end
            end
            S_RXSCAN: begin
                if (i_sts.rx_end) begin
                    o_cmd.tick_done = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.rx_scan = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

@@ design/cfts_dp.sv @@
// Datapath of the CAN frame table scheduler: request registers, both
// slot tables, scan index, pending frame and result register. Depends on cfts_pkg.
module cfts_dp #(
    parameter int SLOTS = cfts_pkg::SlotsDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cfts_pkg::t_cmd      i_cmd,
    output cfts_pkg::t_sts      o_sts,
    input  logic [2:0]          i_op,
    input  logic                i_is_transmit,
    input  logic [2:0]          i_slot,
    input  logic [10:0]         i_frame_id,
    input  logic [3:0]          i_length,
    input  logic [15:0]         i_period_ms,
    input  logic [63:0]         i_payload,
    input  logic [31:0]         i_now,
    input  logic                i_cfg_valid,
    input  logic [3:0]          i_cfg_data,
    output logic                o_res_v,
    output cfts_pkg::t_result   o_res
);
    import cfts_pkg::*;

    localparam int CntW = $clog2(SLOTS + 1);
    localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CmpW = (CntW > 3) ? CntW : 3;
    localparam int OutW = $clog2(MaxOut + 1);
    localparam logic [CntW-1:0] SlotsC = CntW'(SLOTS);
    localparam logic [OutW-1:0] MaxOutC = OutW'(MaxOut);

    // request registers
    logic [2:0]  r_op;
    logic        r_is_tx;
    logic [2:0]  r_slot;
    logic [10:0] r_id;
    logic [3:0]  r_len;
    logic [15:0] r_period;
    logic [63:0] r_payload;
    logic [31:0] r_now;

    // tables and control state
    t_entry          r_tx_tab [SLOTS];
    t_entry          r_rx_tab [SLOTS];
    logic [CntW-1:0] r_tx_cnt;
    logic [CntW-1:0] r_rx_cnt;
    logic [CntW-1:0] r_idx;
    logic [OutW-1:0] r_nout;
    logic            r_pend_v;
    t_result         r_pend;
    logic [3:0]      r_mult;
    logic            r_res_v;
    t_result         r_res;
    logic            n_res_v;
    t_result         n_res;

    t_entry          tx_cur;
    t_entry          rx_cur;
    t_entry          wr_cur;
    t_entry          rd_cur;
    logic [CntW-1:0] sel_cnt;
    logic [IdxW-1:0] slot_i;
    logic [IdxW-1:0] cur_i;
    logic [IdxW-1:0] new_i;
    logic            full;
    logic            slot_ok_sel;
    logic            slot_ok_tx;
    logic            slot_ok_rx;
    logic [31:0]     due_sum;
    logic            due;
    logic [19:0]     span;
    logic [31:0]     fresh_sum;
    logic            fresh_new;
    logic            hit;
    logic            reg_ok;
    logic            rem_ok;
    logic            wr_ok;
    t_result         pend_new;

    // entry selection and checks
    assign cur_i   = r_idx[IdxW-1:0];
    assign slot_i  = r_slot[IdxW-1:0];
    assign sel_cnt = r_is_tx ? r_tx_cnt : r_rx_cnt;
    assign new_i   = sel_cnt[IdxW-1:0];
    assign tx_cur  = r_tx_tab[cur_i];
    assign rx_cur  = r_rx_tab[cur_i];
    assign wr_cur  = r_tx_tab[slot_i];
    assign rd_cur  = r_rx_tab[slot_i];

    assign full        = (sel_cnt >= SlotsC);
    assign slot_ok_sel = (CmpW'(r_slot) < CmpW'(sel_cnt));
    assign slot_ok_tx  = (CmpW'(r_slot) < CmpW'(r_tx_cnt));
    assign slot_ok_rx  = (CmpW'(r_slot) < CmpW'(r_rx_cnt));

    assign reg_ok = i_cmd.exec && (r_op == OP_REG) && !full;
    assign rem_ok = i_cmd.exec && (r_op == OP_REM) && slot_ok_sel;
    assign wr_ok  = i_cmd.exec && (r_op == OP_WRTX) && slot_ok_tx;

    // periodic due test, modulo 2^32
    assign due_sum = tx_cur.ts + 32'(tx_cur.period);
    assign due = (tx_cur.period != 16'd0) && (due_sum < r_now) && (r_nout < MaxOutC);

    // freshness window test, modulo 2^32
    assign span      = 20'(r_mult) * 20'(rx_cur.period);
    assign fresh_sum = rx_cur.ts + 32'(span);
    assign fresh_new = (fresh_sum > r_now);

    assign hit = (rx_cur.ident == r_id);

    assign o_sts.op     = r_op;
    assign o_sts.tx_end = (r_idx >= r_tx_cnt);
    assign o_sts.rx_end = (r_idx >= r_rx_cnt);
    assign o_sts.hit    = hit;

    // frame found due in the tick scan
    always_comb begin
        pend_new = '0;
        pend_new.kind    = KIND_TX;
        pend_new.slot    = 3'(r_idx);
        pend_new.id      = tx_cur.ident;
        pend_new.len     = tx_cur.len;
        pend_new.payload = tx_cur.data & byte_mask(tx_cur.len);
    end

    // next result
    always_comb begin
        n_res = '0;
        n_res_v = 1'b0;
        if (i_cmd.exec) begin
            n_res_v = 1'b1;
            n_res.last = 1'b1;
            unique case (r_op)
                OP_REG: begin
                    if (full) begin
                        n_res.kind = KIND_ERR;
                    end else begin
                        n_res.kind = KIND_ACK;
                        n_res.slot = 3'(sel_cnt);
                    end
                end
                OP_REM: begin
                    if (!slot_ok_sel) begin
                        n_res.kind = KIND_ERR;
                    end else begin
                        n_res.kind = KIND_ACK;
                        n_res.slot = r_slot;
                    end
                end
                OP_WRTX: begin
                    if (!slot_ok_tx) begin
                        n_res.kind = KIND_ERR;
                    end else begin
                        n_res.kind = KIND_ACK;
                        n_res.slot = r_slot;
                        n_res.id   = wr_cur.ident;
                        n_res.len  = wr_cur.len;
                    end
                end
                OP_RDRX: begin
                    if (!slot_ok_rx) begin
                        n_res.kind = KIND_ERR;
                    end else begin
                        n_res.kind    = KIND_RD;
                        n_res.slot    = r_slot;
                        n_res.id      = rd_cur.ident;
                        n_res.len     = rd_cur.len;
                        n_res.payload = rd_cur.data & byte_mask(rd_cur.len);
                        n_res.fresh   = rd_cur.fresh;
                    end
                end
                default: begin
                    n_res.kind = KIND_ERR;
                end
            endcase
        end else if (i_cmd.match && hit) begin
            n_res_v = 1'b1;
            n_res.kind    = KIND_ACK;
            n_res.slot    = 3'(r_idx);
            n_res.matched = 1'b1;
            n_res.last    = 1'b1;
        end else if (i_cmd.no_match) begin
            n_res_v = 1'b1;
            n_res.kind = KIND_ACK;
            n_res.last = 1'b1;
        end else if (i_cmd.tx_scan && due && r_pend_v) begin
            // a later due frame shows the held one was not the final
            n_res_v = 1'b1;
            n_res = r_pend;
        end else if (i_cmd.tick_done) begin
            n_res_v = 1'b1;
            if (r_pend_v) begin
                n_res = r_pend;
            end else begin
                n_res.kind = KIND_ACK;
            end
            n_res.last = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_cnt <= '0;
            r_rx_cnt <= '0;
            r_idx    <= '0;
            r_nout   <= '0;
            r_pend_v <= 1'b0;
            r_mult   <= MultReset;
            r_res_v  <= 1'b0;
        end else begin
            r_res_v <= n_res_v;
            if (i_cfg_valid) begin
                r_mult <= i_cfg_data;
            end
            if (i_cmd.load || i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.match || i_cmd.tx_scan || i_cmd.rx_scan) begin
                r_idx <= r_idx + CntW'(1);
            end
            if (i_cmd.load) begin
                r_nout   <= '0;
                r_pend_v <= 1'b0;
            end else if (i_cmd.tx_scan && due) begin
                r_nout   <= r_nout + OutW'(1);
                r_pend_v <= 1'b1;
            end
            if (reg_ok) begin
                if (r_is_tx) begin
                    r_tx_cnt <= r_tx_cnt + CntW'(1);
                end else begin
                    r_rx_cnt <= r_rx_cnt + CntW'(1);
                end
            end else if (rem_ok) begin
                if (r_is_tx) begin
                    r_tx_cnt <= r_tx_cnt - CntW'(1);
                end else begin
                    r_rx_cnt <= r_rx_cnt - CntW'(1);
                end
            end
        end
    end

    // request, pending frame and result payload
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (i_cmd.load) begin
            r_op      <= i_op;
            r_is_tx   <= i_is_transmit;
            r_slot    <= i_slot;
            r_id      <= i_frame_id;
            r_len     <= (i_length > MaxLen) ? MaxLen : i_length;
            r_period  <= i_period_ms;
            r_payload <= i_payload;
            r_now     <= i_now;
        end
        if (i_cmd.tx_scan && due) begin
            r_pend <= pend_new;
        end
    end

    // table updates
    always_ff @(posedge i_clk) begin
        if (reg_ok) begin
            if (r_is_tx) begin
                r_tx_tab[new_i] <= '{ident: r_id, len: r_len, period: r_period,
                                     ts: 32'd0, data: 64'd0, fresh: 1'b0};
            end else begin
                r_rx_tab[new_i] <= '{ident: r_id, len: r_len, period: r_period,
                                     ts: 32'd0, data: 64'd0, fresh: 1'b0};
            end
        end
        // remove: later entries move down one place
        if (rem_ok) begin
            for (int i = 0; i < SLOTS - 1; i++) begin
                if (i >= int'(r_slot)) begin
                    if (r_is_tx) begin
                        r_tx_tab[i] <= r_tx_tab[i+1];
                    end else begin
                        r_rx_tab[i] <= r_rx_tab[i+1];
                    end
                end
            end
        end
        if (wr_ok) begin
            r_tx_tab[slot_i].data <= r_payload & byte_mask(wr_cur.len);
        end
        if (i_cmd.match && hit) begin
            r_rx_tab[cur_i].ts   <= r_now;
            r_rx_tab[cur_i].data <= r_payload & byte_mask(rx_cur.len);
        end
        if (i_cmd.tx_scan && due) begin
            r_tx_tab[cur_i].ts <= r_now;
        end
        if (i_cmd.rx_scan) begin
            r_rx_tab[cur_i].fresh <= fresh_new;
        end
    end

    assign o_res_v = r_res_v;
    assign o_res   = r_res;

endmodule

@@ design/can_frame_table_scheduler.sv @@
// Top level of the CAN frame table scheduler: sequencer plus datapath.
// Depends on cfts_pkg, cfts_ctrl and cfts_dp.
//
// One request is taken when start is high and busy is low; busy then stays
// high until the request's final result is shown, and the next request may
// be taken in the very cycle that final result is on the ports. Results
// carry no backpressure: each is valid for the single cycle o_strobe is high
// and o_last marks the final one. Register, remove, payload write, read and
// bad opcodes show their one result once the sequencer has passed its execute
// state. A received frame walks the receive table one entry per cycle until
// the first identifier match, or to the end of the table with no match.
// A tick walks the transmit table then the receive table, one entry per cycle,
// its final result showing once both walks are done; due frames stream out
// during the transmit walk, up to six per tick, the last held to tick end.
// o_cfg_ready is always high; write the validity multiple only while idle.
module can_frame_table_scheduler #(
    parameter int SLOTS = cfts_pkg::SlotsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_op,
    input  logic        i_is_transmit,
    input  logic [2:0]  i_slot,
    input  logic [10:0] i_frame_id,
    input  logic [3:0]  i_length,
    input  logic [15:0] i_period_ms,
    input  logic [63:0] i_payload,
    input  logic [31:0] i_now,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data,
    output logic        o_strobe,
    output logic [1:0]  o_kind,
    output logic [2:0]  o_out_slot,
    output logic [10:0] o_out_id,
    output logic [3:0]  o_out_length,
    output logic [63:0] o_out_payload,
    output logic        o_fresh,
    output logic        o_matched,
    output logic        o_last
);
    import cfts_pkg::*;

    t_cmd    cmd;
    t_sts    sts;
    t_result res;

    // sequencer
    cfts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // tables and result register
    cfts_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_op          (i_op),
        .i_is_transmit (i_is_transmit),
        .i_slot        (i_slot),
        .i_frame_id    (i_frame_id),
        .i_length      (i_length),
        .i_period_ms   (i_period_ms),
        .i_payload     (i_payload),
        .i_now         (i_now),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .o_res_v       (o_strobe),
        .o_res         (res)
    );

    // result fields
    assign o_cfg_ready   = 1'b1;
    assign o_kind        = res.kind;
    assign o_out_slot    = res.slot;
    assign o_out_id      = res.id;
    assign o_out_length  = res.len;
    assign o_out_payload = res.payload;
    assign o_fresh       = res.fresh;
    assign o_matched     = res.matched;
    assign o_last        = res.last;

`ifndef SYNTHESIS
    // final result of a request shows once the block is idle again
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |-> !busy)
        else $error("final result shown while busy");

    // a frame that is not the final one comes while the tick is still running
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> busy)
        else $error("non-final result shown while idle");

    // no result in the cycle after a request is taken
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> !o_strobe)
        else $error("result right after request accept");
`endif

endmodule

@@ test/can_frame_table_scheduler_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of can_frame_table_scheduler: a directed table, then random requests
// in phases with different validity multiples. Depends on cfts_pkg and the scheduler RTL.
module can_frame_table_scheduler_test;
    import cfts_pkg::*;

    localparam int ClkPeriod = 8;
    localparam int SlotCount = SlotsDef;
    localparam int IdleLimit = 500;
    localparam int RandomItems = 450;
    localparam int PhaseCount = 4;
    localparam int ShownErrors = 30;
    localparam logic [2:0] OpSpare6 = 3'd6;
    localparam logic [2:0] OpSpare7 = 3'd7;
    localparam logic [63:0] AllOnes = '1;
    localparam logic [10:0] IdPool [8] = '{11'h000, 11'h7FF, 11'h100, 11'h123,
                                          11'h2AA, 11'h555, 11'h03C, 11'h640};

    // one request as driven onto the ports
    typedef struct packed {
        logic [2:0]  op;
        logic        is_tx;
        logic [2:0]  slot;
        logic [10:0] frame_id;
        logic [3:0]  length;
        logic [15:0] period;
        logic [63:0] payload;
        logic [31:0] now;
    } t_request;

    // directed row: request plus an optional hand-written result
    typedef struct packed {
        t_request req;
        logic     typed;
        t_result  result;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_request    req_q;
    logic        typed_q;
    t_result     typed_result_q;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_data;
    logic        o_strobe;
    logic [1:0]  o_kind;
    logic [2:0]  o_out_slot;
    logic [10:0] o_out_id;
    logic [3:0]  o_out_length;
    logic [63:0] o_out_payload;
    logic        o_fresh;
    logic        o_matched;
    logic        o_last;

    // table model and result bookkeeping
    t_entry      tx_slots [SlotCount];
    t_entry      rx_slots [SlotCount];
    int          tx_used = 0;
    int          rx_used = 0;
    logic [3:0]  fresh_multiple = MultReset;
    t_result     step_out [$];
    t_result     results_due [$];
    logic [31:0] now_cursor = '0;
    bit          sender_idles = 1'b1;
    int          errors = 0;
    int          quiet_cycles = 0;
    int          requests_taken = 0;
    int          results_seen = 0;
    int          frames_seen = 0;
    int          cfg_writes = 0;
    int          directed_count = 0;

    can_frame_table_scheduler #(
        .SLOTS(SlotCount)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (req_q.op),
        .i_is_transmit (req_q.is_tx),
        .i_slot        (req_q.slot),
        .i_frame_id    (req_q.frame_id),
        .i_length      (req_q.length),
        .i_period_ms   (req_q.period),
        .i_payload     (req_q.payload),
        .i_now         (req_q.now),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_strobe      (o_strobe),
        .o_kind        (o_kind),
        .o_out_slot    (o_out_slot),
        .o_out_id      (o_out_id),
        .o_out_length  (o_out_length),
        .o_out_payload (o_out_payload),
        .o_fresh       (o_fresh),
        .o_matched     (o_matched),
        .o_last        (o_last)
    );

    // clock
    initial i_clk = 1'b0;
    always #(ClkPeriod / 2) i_clk = ~i_clk;

    // mismatch report, output capped to keep the log short
    task automatic report_error(input string msg);
        errors++;
        if (errors <= ShownErrors) begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_error($sformatf("%s got %h want %h", name, got, want));
        end
    endtask

    // zero every byte at and above position n
    function automatic logic [63:0] keep_bytes(input logic [63:0] d, input logic [3:0] n);
        logic [63:0] r;
        r = d;
        for (int b = 0; b < 8; b++) begin
            if (b >= int'(n)) begin
                r[8*b +: 8] = 8'h00;
            end
        end
        return r;
    endfunction

    // predict the results of one request and update the table model
    task automatic apply_request(input t_request r);
        t_entry      e;
        t_result     x;
        logic [31:0] due_at;
        logic [31:0] span;
        int          n;
        bit          hit;
        x = '0;
        x.kind = KIND_ERR;
        x.last = 1'b1;
        n = 0;
        hit = 1'b0;
        step_out.delete();
        case (r.op)
            OP_REG: begin
                e = '0;
                e.ident = r.frame_id;
                e.len = (r.length > MaxLen) ? MaxLen : r.length;
                e.period = r.period;
                if (r.is_tx && tx_used < SlotCount) begin
                    tx_slots[tx_used] = e;
                    x.kind = KIND_ACK;
                    x.slot = 3'(tx_used);
                    tx_used++;
                end else if (!r.is_tx && rx_used < SlotCount) begin
                    rx_slots[rx_used] = e;
                    x.kind = KIND_ACK;
                    x.slot = 3'(rx_used);
                    rx_used++;
                end
            end
            OP_REM: begin
                // later entries shift down one place
                if (r.is_tx && int'(r.slot) < tx_used) begin
                    for (int i = int'(r.slot); i + 1 < tx_used; i++) begin
                        tx_slots[i] = tx_slots[i + 1];
                    end
                    tx_used--;
                    x.kind = KIND_ACK;
                    x.slot = r.slot;
                end else if (!r.is_tx && int'(r.slot) < rx_used) begin
                    for (int i = int'(r.slot); i + 1 < rx_used; i++) begin
                        rx_slots[i] = rx_slots[i + 1];
                    end
                    rx_used--;
                    x.kind = KIND_ACK;
                    x.slot = r.slot;
                end
            end
            OP_RXF: begin
                // first receive entry with the same identifier takes the frame
                x.kind = KIND_ACK;
                for (int i = 0; i < rx_used; i++) begin
                    if (!hit && rx_slots[i].ident == r.frame_id) begin
                        hit = 1'b1;
                        rx_slots[i].ts = r.now;
                        rx_slots[i].data = keep_bytes(r.payload, rx_slots[i].len);
                        x.slot = 3'(i);
                        x.matched = 1'b1;
                    end
                end
            end
            OP_TICK: begin
                // due periodic transmit entries in table order, wrapping time sum
                for (int i = 0; i < tx_used; i++) begin
                    due_at = tx_slots[i].ts + 32'(tx_slots[i].period);
                    if (n < MaxOut && tx_slots[i].period != '0 && due_at < r.now) begin
                        x = '0;
                        x.kind = KIND_TX;
                        x.slot = 3'(i);
                        x.id = tx_slots[i].ident;
                        x.len = tx_slots[i].len;
                        x.payload = keep_bytes(tx_slots[i].data, tx_slots[i].len);
                        step_out.push_back(x);
                        tx_slots[i].ts = r.now;
                        n++;
                    end
                end
                // receive freshness window
                for (int i = 0; i < rx_used; i++) begin
                    span = 32'(fresh_multiple) * 32'(rx_slots[i].period);
                    rx_slots[i].fresh = (rx_slots[i].ts + span) > r.now;
                end
                if (n == 0) begin
                    x = '0;
                    x.kind = KIND_ACK;
                    x.last = 1'b1;
                end else begin
                    x = step_out.pop_back();
                    x.last = 1'b1;
                    step_out.push_back(x);
                end
            end
            OP_WRTX: begin
                if (int'(r.slot) < tx_used) begin
                    tx_slots[r.slot].data = keep_bytes(r.payload, tx_slots[r.slot].len);
                    x.kind = KIND_ACK;
                    x.slot = r.slot;
                    x.id = tx_slots[r.slot].ident;
                    x.len = tx_slots[r.slot].len;
                end
            end
            OP_RDRX: begin
                if (int'(r.slot) < rx_used) begin
                    x.kind = KIND_RD;
                    x.slot = r.slot;
                    x.id = rx_slots[r.slot].ident;
                    x.len = rx_slots[r.slot].len;
                    x.payload = keep_bytes(rx_slots[r.slot].data, rx_slots[r.slot].len);
                    x.fresh = rx_slots[r.slot].fresh;
                end
            end
            default: begin
            end
        endcase
        if (step_out.size() == 0) begin
            step_out.push_back(x);
        end
    endtask

    // result checking, prediction on each request, watchdog
    always @(posedge i_clk) begin : monitor
        t_result want_r;
        bit      moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (o_strobe) begin
                moved = 1'b1;
                results_seen++;
                if (o_kind == KIND_TX) begin
                    frames_seen++;
                end
                if (results_due.size() == 0) begin
                    report_error($sformatf("result with nothing pending: kind %0d slot %0d id %h",
                                           o_kind, o_out_slot, o_out_id));
                end else begin
                    want_r = results_due.pop_front();
                    check_field("kind", 64'(o_kind), 64'(want_r.kind));
                    check_field("slot", 64'(o_out_slot), 64'(want_r.slot));
                    check_field("id", 64'(o_out_id), 64'(want_r.id));
                    check_field("length", 64'(o_out_length), 64'(want_r.len));
                    check_field("payload", o_out_payload, want_r.payload);
                    check_field("fresh", 64'(o_fresh), 64'(want_r.fresh));
                    check_field("matched", 64'(o_matched), 64'(want_r.matched));
                    check_field("last", 64'(o_last), 64'(want_r.last));
                end
            end
            if (start && !busy) begin
                moved = 1'b1;
                requests_taken++;
                apply_request(req_q);
                if (typed_q) begin
                    results_due.push_back(typed_result_q);
                end else begin
                    foreach (step_out[k]) begin
                        results_due.push_back(step_out[k]);
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                cfg_writes++;
                fresh_multiple = i_cfg_data;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= IdleLimit) begin
                $display("watchdog: no handshake for %0d cycles", IdleLimit);
                $display("can_frame_table_scheduler test failed");
                $finish;
            end
        end
    end

    function automatic t_row make_row(input logic [2:0] op, input logic is_tx,
                                      input logic [2:0] slot, input logic [10:0] id,
                                      input logic [3:0] len, input logic [15:0] period,
                                      input logic [63:0] payload, input logic [31:0] now);
        t_row row;
        row = '0;
        row.req.op = op;
        row.req.is_tx = is_tx;
        row.req.slot = slot;
        row.req.frame_id = id;
        row.req.length = len;
        row.req.period = period;
        row.req.payload = payload;
        row.req.now = now;
        return row;
    endfunction

    // single result with zero payload and fresh, marked last
    function automatic t_row with_result(input t_row row, input t_kind kind,
                                         input logic [2:0] slot, input logic [10:0] id,
                                         input logic [3:0] len, input logic matched);
        t_row w;
        w = row;
        w.typed = 1'b1;
        w.result = '0;
        w.result.kind = kind;
        w.result.slot = slot;
        w.result.id = id;
        w.result.len = len;
        w.result.matched = matched;
        w.result.last = 1'b1;
        return w;
    endfunction

    // random request, biased toward slots and identifiers that exist in the tables
    function automatic t_request random_request();
        t_request    r;
        int unsigned pick;
        int          used;
        r = '0;
        pick = $urandom_range(0, 99);
        if (tx_used + rx_used < 3 && $urandom_range(0, 1) == 1) begin
            pick = 0;
        end
        r.is_tx = 1'($urandom_range(0, 1));
        r.frame_id = ($urandom_range(0, 3) == 0) ? 11'($urandom) : IdPool[$urandom_range(0, 7)];
        r.length = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15))
                                                : 4'($urandom_range(0, 8));
        case ($urandom_range(0, 9))
            0: r.period = '0;
            1: r.period = 16'($urandom);
            default: r.period = 16'($urandom_range(1, 20));
        endcase
        r.payload = {$urandom, $urandom};
        // time mostly creeps forward, with the odd jump anywhere in the range
        if ($urandom_range(0, 59) == 0) begin
            now_cursor = $urandom;
        end else begin
            now_cursor = now_cursor + $urandom_range(0, 24);
        end
        r.now = now_cursor;
        if (pick < 14) begin
            r.op = OP_REG;
        end else if (pick < 22) begin
            r.op = OP_REM;
        end else if (pick < 46) begin
            r.op = OP_RXF;
            if (rx_used > 0 && $urandom_range(0, 4) != 0) begin
                r.frame_id = rx_slots[$urandom_range(0, rx_used - 1)].ident;
            end
        end else if (pick < 70) begin
            r.op = OP_TICK;
        end else if (pick < 82) begin
            r.op = OP_WRTX;
        end else if (pick < 97) begin
            r.op = OP_RDRX;
        end else begin
            r.op = (pick == 97) ? OpSpare6 : OpSpare7;
        end
        // slots mostly inside the part of the table in use
        used = (r.op == OP_WRTX || (r.op == OP_REM && r.is_tx)) ? tx_used : rx_used;
        if (used > 0 && $urandom_range(0, 4) != 0) begin
            r.slot = 3'($urandom_range(0, used - 1));
        end else begin
            r.slot = 3'($urandom_range(0, 7));
        end
        return r;
    endfunction

    // present one request from a falling edge, return at the edge that takes it
    task automatic send_request(input t_row row);
        while (sender_idles && $urandom_range(0, 99) < 7) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        req_q <= row.req;
        typed_q <= row.typed;
        typed_result_q <= row.result;
        start <= 1'b1;
        @(posedge i_clk);
        while (!(start && !busy)) begin
            @(posedge i_clk);
        end
    endtask

    // drop start, wait for all pending results plus the longest walk
    task automatic settle();
        int waited;
        @(negedge i_clk);
        start <= 1'b0;
        waited = 0;
        while (results_due.size() != 0 && waited < IdleLimit) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (2 * SlotCount + 4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // validity multiple write, called from a falling edge while idle
    task automatic write_multiple(input logic [3:0] value);
        while ($urandom_range(0, 99) < 7) begin
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!(i_cfg_valid && o_cfg_ready)) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        t_row       rows [$];
        t_row       row;
        logic [3:0] phase_multiple [PhaseCount];
        i_rst_n = 1'b0;
        start = 1'b0;
        req_q = '0;
        typed_q = 1'b0;
        typed_result_q = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        phase_multiple[0] = 4'd1;
        phase_multiple[1] = 4'd15;
        phase_multiple[2] = 4'($urandom_range(3, 14));
        phase_multiple[3] = MultReset;

        // reset
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty tables: read, write and remove fail, so do the spare opcodes
        rows.push_back(with_result(make_row(OP_RDRX, 0, 0, 0, 0, 0, 0, 0), KIND_ERR, 0, 0, 0, 0));
        rows.push_back(with_result(make_row(OP_WRTX, 1, 0, 0, 0, 0, AllOnes, 0),
                                   KIND_ERR, 0, 0, 0, 0));
        rows.push_back(with_result(make_row(OP_REM, 0, 0, 0, 0, 0, 0, 0), KIND_ERR, 0, 0, 0, 0));
        rows.push_back(with_result(make_row(OpSpare6, 1, 7, 11'h7FF, 4'hF, 16'hFFFF, AllOnes, '1),
                                   KIND_ERR, 0, 0, 0, 0));
        rows.push_back(with_result(make_row(OpSpare7, 0, 0, 0, 0, 0, 0, 0), KIND_ERR, 0, 0, 0, 0));
        // tick with nothing to send, frame nobody listens for
        rows.push_back(with_result(make_row(OP_TICK, 0, 0, 0, 0, 0, 0, 0), KIND_ACK, 0, 0, 0, 0));
        rows.push_back(with_result(make_row(OP_RXF, 0, 0, 11'h7FF, 0, 0, AllOnes, 32'd5),
                                   KIND_ACK, 0, 0, 0, 0));
        // transmit entries: saturated length at widest period, shortest period, never periodic
        rows.push_back(with_result(make_row(OP_REG, 1, 0, 11'h7FF, 4'hF, 16'hFFFF, 0, 0),
                                   KIND_ACK, 0, 0, 0, 0));
        rows.push_back(with_result(make_row(OP_REG, 1, 0, 11'h000, 0, 16'd1, 0, 0),
                                   KIND_ACK, 1, 0, 0, 0));
        rows.push_back(with_result(make_row(OP_REG, 1, 0, 11'h123, 3, 0, 0, 0),
                                   KIND_ACK, 2, 0, 0, 0));
        rows.push_back(with_result(make_row(OP_WRTX, 1, 0, 0, 0, 0, AllOnes, 0),
                                   KIND_ACK, 0, 11'h7FF, MaxLen, 0));
        rows.push_back(with_result(make_row(OP_WRTX, 1, 3, 0, 0, 0, AllOnes, 0),
                                   KIND_ERR, 0, 0, 0, 0));
        // both periodic entries due at the top of time, then the due sum wraps past zero
        rows.push_back(make_row(OP_TICK, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
        rows.push_back(with_result(make_row(OP_TICK, 0, 0, 0, 0, 0, 0, 0), KIND_ACK, 0, 0, 0, 0));
        // receive entries, two sharing one identifier so the first one wins
        rows.push_back(with_result(make_row(OP_REG, 0, 0, 11'h055, 4'd2, 16'd10, 0, 0),
                                   KIND_ACK, 0, 0, 0, 0));
        rows.push_back(with_result(make_row(OP_REG, 0, 0, 11'h055, 4'd8, 16'hFFFF, 0, 0),
                                   KIND_ACK, 1, 0, 0, 0));
        rows.push_back(with_result(make_row(OP_REG, 0, 0, 11'h7FF, 0, 0, 0, 0),
                                   KIND_ACK, 2, 0, 0, 0));
        rows.push_back(with_result(make_row(OP_RXF, 0, 0, 11'h055, 0, 0, AllOnes, 32'd100),
                                   KIND_ACK, 0, 0, 0, 1));
        rows.push_back(make_row(OP_TICK, 0, 0, 0, 0, 0, 0, 32'd110));
        rows.push_back(make_row(OP_RDRX, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(with_result(make_row(OP_RDRX, 0, 7, 0, 0, 0, 0, 0), KIND_ERR, 0, 0, 0, 0));
        rows.push_back(with_result(make_row(OP_REM, 0, 0, 0, 0, 0, 0, 0), KIND_ACK, 0, 0, 0, 0));
        // fill the transmit table, one more is refused
        rows.push_back(with_result(make_row(OP_REG, 1, 0, 11'h2AA, 4'd8, 16'd1, 0, 0),
                                   KIND_ACK, 3, 0, 0, 0));
        rows.push_back(with_result(make_row(OP_REG, 1, 0, 11'h555, 4'd1, 16'd2, 0, 0),
                                   KIND_ACK, 4, 0, 0, 0));
        rows.push_back(with_result(make_row(OP_REG, 1, 0, 11'h001, 4'd5, 16'd3, 0, 0),
                                   KIND_ACK, 5, 0, 0, 0));
        rows.push_back(with_result(make_row(OP_REG, 1, 0, 11'h002, 4'd4, 16'd4, 0, 0),
                                   KIND_ERR, 0, 0, 0, 0));
        rows.push_back(make_row(OP_TICK, 0, 0, 0, 0, 0, 0, 32'h8000_0000));
        directed_count = rows.size();
        foreach (rows[k]) begin
            @(negedge i_clk);
            send_request(rows[k]);
        end

        // random phases, one validity multiple each, phase 1 without sender gaps
        for (int p = 0; p < PhaseCount; p++) begin
            settle();
            write_multiple(phase_multiple[p]);
            sender_idles = (p != 1);
            for (int k = 0; k < RandomItems / PhaseCount; k++) begin
                @(negedge i_clk);
                row = '0;
                row.req = random_request();
                send_request(row);
            end
        end
        settle();

        if (results_due.size() != 0) begin
            report_error($sformatf("%0d results never arrived", results_due.size()));
        end
        $display("covered %0d requests (%0d directed), %0d results checked, %0d transmit frames",
                 requests_taken, directed_count, results_seen, frames_seen);
        $display("validity multiple written %0d times (1, 15, mid, reset value), %0d mismatches",
                 cfg_writes, errors);
        if (errors == 0) begin
            $display("can_frame_table_scheduler test passed");
        end else begin
            $display("can_frame_table_scheduler test failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/cfts_pkg.sv
design/cfts_ctrl.sv
design/cfts_dp.sv
design/can_frame_table_scheduler.sv
test/can_frame_table_scheduler_test.sv
